[sv/bottom_up_merge_sorter_assert.svh]
// Assertion macros for the bottom-up merge sorter.
`ifndef BOTTOM_UP_MERGE_SORTER_ASSERT_SVH
`define BOTTOM_UP_MERGE_SORTER_ASSERT_SVH

// Antecedent implies consequent in the same cycle, checked on aclk outside reset.
`define BMSORT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition never holds, checked on aclk outside reset.
`define BMSORT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

[sv/bmsort_pkg.sv]
// Shared constants and state type for the bottom-up merge sorter.
`default_nettype none

package bmsort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETUP,
        ST_MERGE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[sv/bottom_up_merge_sorter.sv]
// Top level of the bottom-up merge sorter: load, merge passes and readout.
//
// The block collects a batch of signed 32-bit values, one per input beat, into
// buffer 0. The beat with s_tlast high closes the batch (its value belongs to
// it). Values arriving once MAX_ELEMENTS are held are dropped, and every
// result of that batch then carries m_tuser = 1. The batch is sorted in
// ascending signed order by bottom-up merge passes that ping-pong between two
// on-chip buffers with registered reads; each pass merges adjacent runs
// of width 1, 2, 4, ... and copies a run without partner unchanged. The sorted
// values leave as one beat each, m_tlast on the greatest. Each merge pass is
// limited by the single write port of the destination buffer and spends a
// setup step on each run pair; readout delivers one value per cycle while
// m_tready stays high. s_tready is high only while loading: a new batch
// starts after the last result of the previous one has been taken. No
// clearing pass is needed after reset.
`default_nettype none

module bottom_up_merge_sorter #(
    parameter int MAX_ELEMENTS = bmsort_pkg::MAX_ELEMENTS
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // input channel
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [bmsort_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire                          s_tlast,   // last value of the batch
    // result channel
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [bmsort_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                         m_tlast,   // greatest value of the batch
    output logic                         m_tuser    // [0] overflow
);

    localparam int DW = bmsort_pkg::DATA_W;
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int SW = CW + 2;   // room for segment bounds before clamping

    // ------------------------------------------------------------------
    // Storage: two ping-pong buffers, one write and two read ports each.
    // ------------------------------------------------------------------
    logic [DW-1:0] mem0 [MAX_ELEMENTS];
    logic [DW-1:0] mem1 [MAX_ELEMENTS];
    logic [DW-1:0] rd0_a_reg, rd0_b_reg, rd1_a_reg, rd1_b_reg;

    logic          wr0_en, wr1_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] addr_a, addr_b;

    // ------------------------------------------------------------------
    // Control and pointer registers
    // ------------------------------------------------------------------
    bmsort_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;       // batch size n
    logic          ovf_reg, ovf_next;
    logic [SW-1:0] wid_reg, wid_next;       // current run width
    logic [CW-1:0] seg_reg, seg_next;       // start of the run pair
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;           // head of left run
    logic [CW-1:0] j_reg, j_next;           // head of right run
    logic [CW-1:0] k_reg, k_next;           // destination index
    logic          src_reg, src_next;       // 0: buffer 0 is the source
    logic [CW-1:0] rptr_reg, rptr_next;     // readout issue pointer

    // readout pipeline: read in flight, skid stage, output stage
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic          skid_v_reg, skid_v_next;
    logic [DW-1:0] skid_data_reg, skid_data_next;
    logic          skid_last_reg, skid_last_next;
    logic          m_valid_reg, m_valid_next;
    logic [DW-1:0] m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    // ------------------------------------------------------------------
    // Shared combinational terms
    // ------------------------------------------------------------------
    logic          s_fire;
    logic          has_room;
    logic [CW-1:0] cnt_after;
    logic [DW-1:0] src_a, src_b;
    logic          a_avail, b_avail, take_a;
    logic [DW-1:0] merge_val;
    logic [CW-1:0] k_inc;
    logic          seg_end, pass_end, sort_done;
    logic [SW-1:0] wid_dbl, n_ext, mid_s, hi_s;
    logic [CW-1:0] mid_c, hi_c;
    logic [1:0]    occ, occ_left;
    logic          taken, room, rd_more, issue, drained;

    assign s_fire    = s_tvalid && s_tready;
    assign has_room  = cnt_reg < CW'(MAX_ELEMENTS);
    assign cnt_after = has_room ? cnt_reg + CW'(1) : cnt_reg;

    assign src_a     = src_reg ? rd1_a_reg : rd0_a_reg;
    assign src_b     = src_reg ? rd1_b_reg : rd0_b_reg;
    assign a_avail   = i_reg < mid_reg;
    assign b_avail   = j_reg < hi_reg;
    // equal keys take the right run; they are indistinguishable anyway
    assign take_a    = a_avail && (!b_avail || ($signed(src_a) < $signed(src_b)));
    assign merge_val = take_a ? src_a : src_b;

    assign k_inc     = k_reg + CW'(1);
    assign seg_end   = k_inc == hi_reg;
    assign pass_end  = hi_reg == cnt_reg;
    assign wid_dbl   = {wid_reg[SW-2:0], 1'b0};
    assign n_ext     = SW'(cnt_reg);
    assign sort_done = wid_dbl >= n_ext;

    // clamp the run pair bounds to the batch size
    assign mid_s     = SW'(seg_reg) + wid_reg;
    assign hi_s      = SW'(seg_reg) + wid_dbl;
    assign mid_c     = (mid_s > n_ext) ? cnt_reg : mid_s[CW-1:0];
    assign hi_c      = (hi_s > n_ext) ? cnt_reg : hi_s[CW-1:0];

    // readout credit: never more than two beats held or in flight
    assign occ       = {1'b0, m_valid_reg} + {1'b0, skid_v_reg} + {1'b0, pend_reg};
    assign taken     = m_valid_reg && m_tready;
    assign occ_left  = occ - {1'b0, taken};
    assign room      = occ_left < 2'd2;
    assign rd_more   = rptr_reg != cnt_reg;
    assign issue     = (state_reg == bmsort_pkg::ST_OUT) && rd_more && room;
    assign drained   = !rd_more && (occ_left == 2'd0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bmsort_pkg::ST_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = (cnt_after > CW'(1)) ? bmsort_pkg::ST_SETUP
                                                      : bmsort_pkg::ST_OUT;
                end
            end
            bmsort_pkg::ST_SETUP: begin
                state_next = bmsort_pkg::ST_MERGE;
            end
            bmsort_pkg::ST_MERGE: begin
                if (seg_end) begin
                    state_next = (pass_end && sort_done) ? bmsort_pkg::ST_OUT
                                                         : bmsort_pkg::ST_SETUP;
                end
            end
            bmsort_pkg::ST_OUT: begin
                if (drained) begin
                    state_next = bmsort_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = bmsort_pkg::ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the state machine: memory ports and pointer updates
    // ------------------------------------------------------------------
    always_comb begin
        wr0_en    = 1'b0;
        wr1_en    = 1'b0;
        wr_addr   = k_reg[AW-1:0];
        wr_data   = merge_val;
        addr_a    = rptr_reg[AW-1:0];
        addr_b    = j_reg[AW-1:0];
        s_tready  = 1'b0;

        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        wid_next  = wid_reg;
        seg_next  = seg_reg;
        mid_next  = mid_reg;
        hi_next   = hi_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        src_next  = src_reg;
        rptr_next = rptr_reg;

        case (state_reg)
            bmsort_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                wr_addr  = cnt_reg[AW-1:0];
                wr_data  = s_tdata;
                if (s_fire) begin
                    // store while there is room, else drop and flag
                    wr0_en   = has_room;
                    cnt_next = cnt_after;
                    ovf_next = ovf_reg || !has_room;
                    if (s_tlast) begin
                        wid_next  = SW'(1);
                        seg_next  = '0;
                        src_next  = 1'b0;
                        rptr_next = '0;
                    end
                end
            end
            bmsort_pkg::ST_SETUP: begin
                // prime both heads of the run pair
                mid_next = mid_c;
                hi_next  = hi_c;
                i_next   = seg_reg;
                j_next   = mid_c;
                k_next   = seg_reg;
                addr_a   = seg_reg[AW-1:0];
                addr_b   = mid_c[AW-1:0];
            end
            bmsort_pkg::ST_MERGE: begin
                wr0_en  = src_reg;
                wr1_en  = !src_reg;
                k_next  = k_inc;
                i_next  = take_a ? i_reg + CW'(1) : i_reg;
                j_next  = take_a ? j_reg : j_reg + CW'(1);
                // fetch the new heads for the next cycle
                addr_a  = i_next[AW-1:0];
                addr_b  = j_next[AW-1:0];
                if (seg_end) begin
                    if (pass_end) begin
                        src_next = !src_reg;
                        wid_next = wid_dbl;
                        seg_next = '0;
                    end else begin
                        seg_next = hi_reg;
                    end
                end
            end
            bmsort_pkg::ST_OUT: begin
                if (issue) begin
                    rptr_next = rptr_reg + CW'(1);
                end
                if (drained) begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default: begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Readout stages: read data lands in the output stage, or in the skid
    // stage while the output stage is stalled or the skid stage still holds a beat.
    // ------------------------------------------------------------------
    always_comb begin
        pend_next      = issue;
        pend_last_next = (rptr_reg + CW'(1)) == cnt_reg;
        skid_v_next    = skid_v_reg;
        skid_data_next = skid_data_reg;
        skid_last_next = skid_last_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;

        if (!m_valid_reg || m_tready) begin
            if (skid_v_reg) begin
                m_valid_next   = 1'b1;
                m_data_next    = skid_data_reg;
                m_last_next    = skid_last_reg;
                skid_v_next    = pend_reg;
                skid_data_next = src_a;
                skid_last_next = pend_last_reg;
            end else if (pend_reg) begin
                m_valid_next   = 1'b1;
                m_data_next    = src_a;
                m_last_next    = pend_last_reg;
            end else begin
                m_valid_next   = 1'b0;
            end
        end else if (pend_reg) begin
            skid_v_next    = 1'b1;
            skid_data_next = src_a;
            skid_last_next = pend_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    // overflow flag holds for the whole readout of the batch
    assign m_tuser  = ovf_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr0_en) begin
            mem0[wr_addr] <= wr_data;
        end
        rd0_a_reg <= mem0[addr_a];
        rd0_b_reg <= mem0[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (wr1_en) begin
            mem1[wr_addr] <= wr_data;
        end
        rd1_a_reg <= mem1[addr_a];
        rd1_b_reg <= mem1[addr_b];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bmsort_pkg::ST_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            src_reg     <= 1'b0;
            rptr_reg    <= '0;
            pend_reg    <= 1'b0;
            skid_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            src_reg     <= src_next;
            rptr_reg    <= rptr_next;
            pend_reg    <= pend_next;
            skid_v_reg  <= skid_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wid_reg       <= wid_next;
        seg_reg       <= seg_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        pend_last_reg <= pend_last_next;
        skid_data_reg <= skid_data_next;
        skid_last_reg <= skid_last_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "bottom_up_merge_sorter_assert.svh"

    `BMSORT_ASSERT_IMP(a_merge_has_head, state_reg == bmsort_pkg::ST_MERGE, a_avail || b_avail, "merge cycle with both runs exhausted")
    `BMSORT_ASSERT_IMP(a_skid_behind_out, skid_v_reg, m_valid_reg, "skid stage full while output stage empty")
    `BMSORT_ASSERT_NEVER(a_readout_credit, pend_reg && skid_v_reg && m_valid_reg, "readout holds more than two beats")
    `BMSORT_ASSERT_IMP(a_no_load_during_out, m_valid_reg, !s_tready, "input accepted while results pending")

endmodule

`default_nettype wire
